// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ----- rtl/core/gcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Gray contrast stretch package
// Shared constants for the fixed-point to 8-bit gray converter.
// ----------------------------------------------------------------------------
package gcs_pkg;

    localparam int VALUE_BITS_DEF = 24;   // Q15.8 pixel word
    localparam int FRAC_BITS      = 8;    // fraction bits of a pixel
    localparam int GRAY_BITS      = 8;
    localparam int GRAY_MAX       = 255;
    localparam int ONE_FIXED      = 256;  // 1.0, divisor of a flat frame

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

endpackage

// ----- rtl/core/gray_contrast_stretch_to_byte.sv -----
// ----------------------------------------------------------------------------
// Gray contrast stretch to byte
// Min/max contrast stretch of signed fixed-point gray pixels to 8-bit gray.
// ----------------------------------------------------------------------------
// Each frame is sent twice. Measure beats (operation 0) update the running
// minimum and maximum, restarted by a beat flagged first_of_frame, and give no
// output beat; they pass through EXEC and return to idle. Convert beats
// (operation 1) give one gray byte each. In clip mode (scale_mode 0) the
// integer part of the pixel is clamped to 0..255 in EXEC, and the byte is
// loaded into the output register from HOLD once that register is free.
// In scale mode (scale_mode 1, the reset value) the byte is
// floor((v - min) * 255 / (max - min)), saturated to 0..255, with a divisor of
// 1.0 when max equals min. Pixels with v - min negative or not below the
// divisor saturate in PREP; the rest go through a radix-2 restoring divider
// that retires one quotient bit per cycle, in 8 divider iterations after the
// EXEC and PREP setup steps, before the output load in HOLD. The block holds
// one pixel at a time, so the divider sets the scale-mode convert rate. The
// next input beat is taken while a finished byte still waits on m_ready.
// Write scale_mode through the cfg channel only while the block is idle.
// ----------------------------------------------------------------------------
module gray_contrast_stretch_to_byte #(
    parameter int VALUE_BITS = gcs_pkg::VALUE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // pixel input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic                                  s_first_of_frame,
    input  logic signed [VALUE_BITS-1:0]          s_pixel_value,
    // gray output channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic        [gcs_pkg::GRAY_BITS-1:0]  m_gray,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_data
);
    import gcs_pkg::*;

    `include "assert_macros.svh"

    // Difference width: one bit more than a pixel so v - min never overflows.
    localparam int DW = VALUE_BITS + 1;
    // Width for the clip compare; always wide enough to hold 255.
    localparam int EW = VALUE_BITS + 2;
    localparam int PW = DW + GRAY_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    localparam logic [GRAY_BITS-1:0] GRAY_FULL = GRAY_BITS'(GRAY_MAX);

    // control
    logic [2:0]                  state_reg, state_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        scale_mode_reg, scale_mode_next;
    logic signed [VALUE_BITS-1:0] min_reg, min_next;
    logic signed [VALUE_BITS-1:0] max_reg, max_next;
    // payload
    logic                        op_reg, op_next;
    logic                        first_reg, first_next;
    logic signed [VALUE_BITS-1:0] v_reg, v_next;
    logic signed [DW-1:0]        num_reg, num_next;
    logic        [DW-1:0]        den_reg, den_next;
    logic        [DW-1:0]        rem_reg, rem_next;
    logic        [GRAY_BITS-1:0] nlo_reg, nlo_next;
    logic        [GRAY_BITS-1:0] quot_reg, quot_next;
    logic        [GRAY_BITS-1:0] m_gray_reg, m_gray_next;

    logic                        s_take;
    logic                        out_free;
    logic signed [DW-1:0]        diff_w;
    logic signed [DW-1:0]        num_w;
    logic        [EW-1:0]        ip_w;
    logic        [PW-1:0]        prod_w;
    logic        [DW:0]          trial_w;
    logic                        ge_w;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_gray    = m_gray_reg;

    // Datapath terms shared by the states.
    always_comb begin
        num_w   = $signed({v_reg[VALUE_BITS-1], v_reg}) -
                  $signed({min_reg[VALUE_BITS-1], min_reg});
        diff_w  = $signed({max_reg[VALUE_BITS-1], max_reg}) -
                  $signed({min_reg[VALUE_BITS-1], min_reg});
        ip_w    = EW'(v_reg[VALUE_BITS-1:FRAC_BITS]);
        // num * 255 as (num << 8) - num
        prod_w  = {num_reg, {GRAY_BITS{1'b0}}} - PW'($unsigned(num_reg));
        trial_w = {rem_reg, nlo_reg[GRAY_BITS-1]};
        ge_w    = (trial_w >= {1'b0, den_reg});
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        scale_mode_next = scale_mode_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        op_next         = op_reg;
        first_next      = first_reg;
        v_next          = v_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        nlo_next        = nlo_reg;
        quot_next       = quot_reg;
        m_gray_next     = m_gray_reg;

        if (cfg_valid && cfg_ready) begin
            scale_mode_next = cfg_data;
        end

        // Drop the output beat once taken; a new load below overrides.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    op_next    = s_operation;
                    first_next = s_first_of_frame;
                    v_next     = s_pixel_value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_MEASURE) begin
                    // Restart or widen the measured range.
                    if (first_reg) begin
                        min_next = v_reg;
                        max_next = v_reg;
                    end else begin
                        if (v_reg < min_reg) begin
                            min_next = v_reg;
                        end
                        if (v_reg > max_reg) begin
                            max_next = v_reg;
                        end
                    end
                    state_next = ST_IDLE;
                end else if (!scale_mode_reg) begin
                    // Clip: negative gives 0, large integer part gives 255.
                    if (v_reg[VALUE_BITS-1]) begin
                        quot_next = '0;
                    end else if (ip_w > EW'(GRAY_MAX)) begin
                        quot_next = GRAY_FULL;
                    end else begin
                        quot_next = ip_w[GRAY_BITS-1:0];
                    end
                    state_next = ST_HOLD;
                end else begin
                    num_next   = num_w;
                    den_next   = (max_reg > min_reg) ? $unsigned(diff_w) : DW'(ONE_FIXED);
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (num_reg[DW-1]) begin
                    quot_next  = '0;
                    state_next = ST_HOLD;
                end else if ($unsigned(num_reg) >= den_reg) begin
                    quot_next  = GRAY_FULL;
                    state_next = ST_HOLD;
                end else begin
                    // num < den, so prod >> 8 is already below the divisor.
                    rem_next   = prod_w[PW-1:GRAY_BITS];
                    nlo_next   = prod_w[GRAY_BITS-1:0];
                    quot_next  = '0;
                    cnt_next   = 3'(GRAY_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // One restoring step: shift in a dividend bit, subtract if it fits.
                rem_next  = ge_w ? DW'(trial_w - {1'b0, den_reg}) : trial_w[DW-1:0];
                nlo_next  = {nlo_reg[GRAY_BITS-2:0], 1'b0};
                quot_next = {quot_reg[GRAY_BITS-2:0], ge_w};
                cnt_next  = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_gray_next  = quot_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            scale_mode_reg <= 1'b1;
            min_reg        <= '0;
            max_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            scale_mode_reg <= scale_mode_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        first_reg  <= first_next;
        v_reg      <= v_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        nlo_reg    <= nlo_next;
        quot_reg   <= quot_next;
        m_gray_reg <= m_gray_next;
    end

    `ASSERT_CLK(a_range_ordered, aclk, aresetn,
        min_reg <= max_reg,
        "measured min above max")
    `ASSERT_CLK(a_rem_below_den, aclk, aresetn,
        (state_reg != ST_DIV) || (rem_reg < den_reg),
        "divider remainder not below divisor")
    `ASSERT_CLK(a_div_quot_range, aclk, aresetn,
        (state_reg == ST_DIV && cnt_reg == 3'd0) |=> (quot_reg != GRAY_FULL),
        "divided quotient reached saturation value")
    `ASSERT_CLK(a_measure_returns, aclk, aresetn,
        (state_reg == ST_EXEC && op_reg == OP_MEASURE) |=> (state_reg == ST_IDLE),
        "measure beat did not return to idle")

endmodule

// ----- sim/gray_contrast_stretch_to_byte_tb.sv -----
// ----------------------------------------------------------------------------
// Gray contrast stretch to byte testbench
// Drives measure and convert passes of pixel frames into the converter, in
// both scale and clip mode and under several idle and stall profiles, and
// checks each gray beat against a stretch/clip predictor or a pinned value.
// ----------------------------------------------------------------------------
module gray_contrast_stretch_to_byte_tb;

    import gcs_pkg::*;

    localparam int PIX_W         = VALUE_BITS_DEF;
    localparam int NUM_DIR       = 28;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 135;   // 8 phases of this give ~1100 beats
    localparam int SETTLE_CYCLES = 16;    // a measure beat may still be in flight
    localparam int DRAIN_CYCLES  = 30;
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int WATCHDOG_MAX  = 4000;

    typedef enum logic {ROW_PIXEL, ROW_MODE} row_kind_t;

    // One directed row: a pixel beat, or a scale_mode write (mode field).
    // When pin is set, gray is the typed-in expectation for that beat.
    typedef struct packed {
        row_kind_t        kind;
        logic             op;
        logic             first;
        logic [PIX_W-1:0] pix;
        logic             pin;
        logic [7:0]       gray;
        logic             mode;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                    aclk             = 1'b0;
    logic                    aresetn          = 1'b0;
    logic                    s_valid          = 1'b0;
    logic                    s_operation      = OP_MEASURE;
    logic                    s_first_of_frame = 1'b0;
    logic signed [PIX_W-1:0] s_pixel_value    = '0;
    logic                    m_ready          = 1'b0;
    logic                    cfg_valid        = 1'b0;
    logic                    cfg_data         = 1'b0;
    logic                    s_ready;
    logic                    m_valid;
    logic [GRAY_BITS-1:0]    m_gray;
    logic                    cfg_ready;

    // Pinned expectation, driven along with the pixel payload
    logic                    pin_en  = 1'b0;
    logic [7:0]              pin_val = '0;

    // Predictor state: a copy of the block's registers
    logic                    mode_scale;
    longint                  stretch_min;
    longint                  stretch_max;
    logic [7:0]              gray_expect_q[$];

    int                      error_count = 0;
    int                      items_sent  = 0;
    int                      quiet_cycles = 0;
    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;
    int                      hold_req_seq  = 0;
    int                      hold_seen_seq = 0;
    int                      hold_left     = 0;

    dir_row_t                dir_rows [NUM_DIR];

    always #5 aclk = ~aclk;

    gray_contrast_stretch_to_byte #(
        .VALUE_BITS (PIX_W)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_first_of_frame (s_first_of_frame),
        .s_pixel_value    (s_pixel_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_gray           (m_gray),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Measure beat: restart the range on a first pixel, else widen it.
    function automatic void track_extremes(input logic first,
                                           input logic signed [PIX_W-1:0] pix);
        longint v;
        v = pix;
        if (first) begin
            stretch_min = v;
            stretch_max = v;
        end else begin
            if (v < stretch_min) stretch_min = v;
            if (v > stretch_max) stretch_max = v;
        end
    endfunction

    // Convert beat: stretch by the measured range, or clip the integer part.
    function automatic logic [7:0] predict_gray(input logic signed [PIX_W-1:0] pix);
        longint v, num, den, q;
        v = pix;
        if (mode_scale) begin
            num = v - stretch_min;
            // flat range divides by 1.0
            den = (stretch_max > stretch_min) ? stretch_max - stretch_min : ONE_FIXED;
            q   = (num < 0) ? 0 : (num * GRAY_MAX) / den;
        end else begin
            q = (v < 0) ? 0 : (v >>> FRAC_BITS);
        end
        if (q > GRAY_MAX) q = GRAY_MAX;
        return q[7:0];
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard and watchdog: sample every handshake at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        logic [7:0] want_gray;
        if (!aresetn) begin
            mode_scale  = 1'b1;
            stretch_min = 0;
            stretch_max = 0;
        end else begin
            if (cfg_valid && cfg_ready) mode_scale = cfg_data;

            // Retire the oldest expectation before queuing a new one
            if (m_valid && m_ready) begin
                if (gray_expect_q.size() == 0) begin
                    $error("gray beat with no expectation pending: actual %0d", m_gray);
                    error_count++;
                end else begin
                    want_gray = gray_expect_q.pop_front();
                    if (m_gray !== want_gray) begin
                        $error("gray mismatch: expected %0d, actual %0d", want_gray, m_gray);
                        error_count++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_operation == OP_MEASURE)
                    track_extremes(s_first_of_frame, s_pixel_value);
                else
                    gray_expect_q.push_back(pin_en ? pin_val : predict_gray(s_pixel_value));
            end

            // Count cycles in which no channel moves a beat
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("Timeout: no beat for %0d cycles, %0d gray beats outstanding",
                         quiet_cycles, gray_expect_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req_seq != hold_seen_seq) begin
            // start a hold-off and let the block back up into its input
            hold_seen_seq <= hold_req_seq;
            hold_left     <= HOLD_CYCLES;
            m_ready       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one pixel beat and return in the step it is accepted, with valid
    // still high: the caller either sends the next beat or drops valid then.
    task automatic send_pixel(input logic op, input logic first,
                              input logic signed [PIX_W-1:0] pix,
                              input logic pin, input logic [7:0] pin_gray);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_first_of_frame <= first;
        s_pixel_value    <= pix;
        pin_en           <= pin;
        pin_val          <= pin_gray;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid, drain the block, then write scale_mode.
    task automatic write_scale_mode(input logic mode);
        s_valid <= 1'b0;
        while (gray_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // A well-formed frame: measure pass, then convert pass over the same
    // pixels, with a few strays outside the measured range.
    task automatic send_frame();
        logic signed [PIX_W-1:0] vals [12];
        logic signed [PIX_W-1:0] base, pix;
        int                      n, spread_kind, pick;
        n           = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
        spread_kind = $urandom_range(4);
        base        = PIX_W'($urandom);
        if (spread_kind == 4) base = PIX_W'($urandom_range(32'h11000)) - PIX_W'(32'h800);
        for (int i = 0; i < n; i++) begin
            case (spread_kind)
                0:       vals[i] = base;                                   // flat frame
                1:       vals[i] = base + PIX_W'($urandom_range(255));
                2:       vals[i] = base + PIX_W'($urandom_range(32'hFFFF));
                3:       vals[i] = PIX_W'($urandom);
                default: vals[i] = base + PIX_W'($urandom_range(32'hFFFF));
            endcase
        end
        for (int i = 0; i < n; i++)
            send_pixel(OP_MEASURE, i == 0, vals[i], 1'b0, 8'd0);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)      pix = vals[i];
            else if (pick < 85) pix = vals[$urandom_range(n - 1)];
            else                pix = PIX_W'($urandom);
            // first_of_frame means nothing on a convert beat; toggle it anyway
            send_pixel(OP_CONVERT, (i == 0) || ($urandom_range(9) == 0), pix, 1'b0, 8'd0);
        end
    endtask

    // Noise: random operations, flags and values, in no particular order.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_pixel(logic'($urandom_range(1)), logic'($urandom_range(1)),
                       PIX_W'($urandom), 1'b0, 8'd0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_end;

        // kind       op          first pix           pin   gray    mode
        dir_rows = '{
            // after reset the range is zero and flat: divide by 1.0
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h000000, 1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h000100, 1'b1, 8'd255, 1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h800000, 1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h7FFFFF, 1'b1, 8'd255, 1'b0},
            // measure without a first pixel widens from zero
            '{ROW_PIXEL, OP_MEASURE, 1'b0, 24'h000200, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h000100, 1'b0, 8'd0,   1'b0},
            // full-scale range
            '{ROW_PIXEL, OP_MEASURE, 1'b1, 24'h800000, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_MEASURE, 1'b0, 24'h7FFFFF, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h800000, 1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h7FFFFF, 1'b1, 8'd255, 1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b1, 24'h000000, 1'b0, 8'd0,   1'b0},
            // flat frame at 16.0
            '{ROW_PIXEL, OP_MEASURE, 1'b1, 24'h001000, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_MEASURE, 1'b0, 24'h001000, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h001000, 1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h001080, 1'b0, 8'd0,   1'b0},
            // below the minimum saturates low
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h000FFF, 1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_MEASURE, 1'b0, 24'h000800, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h000C00, 1'b0, 8'd0,   1'b0},
            // above the maximum saturates high
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h002000, 1'b1, 8'd255, 1'b0},
            // clip mode: integer part clamped to a byte
            '{ROW_MODE,  OP_MEASURE, 1'b0, 24'h000000, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h000000, 1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'hFFFF00, 1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h00FF80, 1'b1, 8'd255, 1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h010000, 1'b1, 8'd255, 1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h007F80, 1'b1, 8'd127, 1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h7FFFFF, 1'b1, 8'd255, 1'b0},
            '{ROW_PIXEL, OP_CONVERT, 1'b0, 24'h0000FF, 1'b1, 8'd0,   1'b0},
            '{ROW_MODE,  OP_MEASURE, 1'b0, 24'h000000, 1'b0, 8'd0,   1'b1}
        };

        // Hold reset, then release it once
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: walk the table with no idling on either side
        for (int r = 0; r < NUM_DIR; r++) begin
            if (dir_rows[r].kind == ROW_MODE)
                write_scale_mode(dir_rows[r].mode);
            else
                send_pixel(dir_rows[r].op, dir_rows[r].first, dir_rows[r].pix,
                           dir_rows[r].pin, dir_rows[r].gray);
        end

        // Random part: idle profiles in pairs, scale mode then clip mode
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_scale_mode(~p[0]);
            case (p / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 76; end
                default: begin send_idle_pct = 22; recv_stall_pct <= 22; end
            endcase
            // hold the receiver off while the sender keeps offering beats
            if (p == 0 || p == 3) hold_req_seq <= hold_req_seq + 1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 15) send_noise();
                else                         send_frame();
            end
        end

        // Drain: drop valid, let every gray beat out, then allow the tail
        s_valid <= 1'b0;
        recv_stall_pct <= 0;
        while (gray_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
